### hw/rtl/toh_pkg.sv
// Shared types, sizes and helpers for the timestamped orientation history.
// Used by toh_ctrl, toh_datapath and timestamped_orientation_history_unit.
`timescale 1ns / 1ps

package toh_pkg;

   // Number of samples the history keeps.
   localparam int DEPTH   = 128;
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int STAMP_W = 48;
   localparam int VAL_W   = 16;

   // Operation codes carried in the op field of a request word.
   localparam logic OP_PUSH  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // One stored sample.
   typedef struct packed {
      logic [STAMP_W-1:0]      stamp;
      logic signed [VAL_W-1:0] orient_w;
      logic signed [VAL_W-1:0] orient_x;
      logic signed [VAL_W-1:0] orient_y;
      logic signed [VAL_W-1:0] orient_z;
      logic signed [VAL_W-1:0] yaw;
      logic signed [VAL_W-1:0] pitch;
   } entry_type;

   // One result word.
   typedef struct packed {
      logic                    found;
      logic signed [VAL_W-1:0] orient_w;
      logic signed [VAL_W-1:0] orient_x;
      logic signed [VAL_W-1:0] orient_y;
      logic signed [VAL_W-1:0] orient_z;
      logic signed [VAL_W-1:0] yaw;
      logic signed [VAL_W-1:0] pitch;
   } result_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic push_wr;    // store the incoming sample
      logic q_start;    // latch the target, read the oldest sample
      logic rd_newest;  // read the newest sample
      logic srch_init;  // set up the search window, read its middle
      logic srch_step;  // narrow the window by one compare
      logic near_cur;   // hold the first sample at or after the target
      logic res_zero;   // result is the empty answer
      logic res_rd;     // result is the sample just read
      logic res_pick;   // result is the nearer of the two neighbors
      logic out_load;   // move the result into the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic empty;
      logic tgt_le_rd;
      logic tgt_ge_newest;
      logic srch_done;
      logic out_free;
   } status_type;

   // Physical slot of logical position pos, counted from the oldest sample.
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] oldest,
                                                input logic [CNT_W-1:0] pos);
      logic [CNT_W:0] sum;
      begin
         sum = (CNT_W+1)'(oldest) + (CNT_W+1)'(pos);
         if (sum >= (CNT_W+1)'(DEPTH)) begin
            sum = sum - (CNT_W+1)'(DEPTH);
         end
         return sum[IDX_W-1:0];
      end
   endfunction

endpackage

### hw/rtl/timestamped_orientation_history_unit.sv
// Top level of the timestamped orientation history unit.
// Depends on toh_pkg, toh_ctrl and toh_datapath.
`timescale 1ns / 1ps

// The unit keeps the latest toh_pkg::DEPTH orientation samples (stamp, quaternion,
// yaw, pitch) in a single-port-read ring memory. A push word (op = 0) stores the
// sample as it is accepted; its stamp is raised to the newest stored stamp
// if it would go backward, and a full ring drops its oldest sample. A push gives
// no result. A query word (op = 1) returns the stored sample nearest to the given
// time, the later one on a tie; an empty history answers with found = 0 and all
// other fields zero. Queries are served one at a time. A target outside the
// stored span is answered from the oldest or the newest sample; a target inside
// it goes through a binary search, which makes one memory read per step. A query
// also waits while the output register stays full. A finished result sits in
// that output register, so the next word is accepted while it waits.

module timestamped_orientation_history_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_op,
   input  logic [toh_pkg::STAMP_W-1:0]         req_stamp_us,
   input  logic signed [toh_pkg::VAL_W-1:0]    req_orient_w,
   input  logic signed [toh_pkg::VAL_W-1:0]    req_orient_x,
   input  logic signed [toh_pkg::VAL_W-1:0]    req_orient_y,
   input  logic signed [toh_pkg::VAL_W-1:0]    req_orient_z,
   input  logic signed [toh_pkg::VAL_W-1:0]    req_yaw_angle,
   input  logic signed [toh_pkg::VAL_W-1:0]    req_pitch_angle,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_found,
   output logic signed [toh_pkg::VAL_W-1:0]    rsp_res_orient_w,
   output logic signed [toh_pkg::VAL_W-1:0]    rsp_res_orient_x,
   output logic signed [toh_pkg::VAL_W-1:0]    rsp_res_orient_y,
   output logic signed [toh_pkg::VAL_W-1:0]    rsp_res_orient_z,
   output logic signed [toh_pkg::VAL_W-1:0]    rsp_res_yaw,
   output logic signed [toh_pkg::VAL_W-1:0]    rsp_res_pitch
);

   toh_pkg::cmd_type    cmd;
   toh_pkg::status_type status;
   toh_pkg::result_type rsp_word;

   // The controller only issues commands while it holds an accepted word.
   toh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath owns the ring memory, the search window and the output register.
   toh_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .in_stamp  (req_stamp_us),
      .in_w      (req_orient_w),
      .in_x      (req_orient_x),
      .in_y      (req_orient_y),
      .in_z      (req_orient_z),
      .in_yaw    (req_yaw_angle),
      .in_pitch  (req_pitch_angle),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   assign rsp_found        = rsp_word.found;
   assign rsp_res_orient_w = rsp_word.orient_w;
   assign rsp_res_orient_x = rsp_word.orient_x;
   assign rsp_res_orient_y = rsp_word.orient_y;
   assign rsp_res_orient_z = rsp_word.orient_z;
   assign rsp_res_yaw      = rsp_word.yaw;
   assign rsp_res_pitch    = rsp_word.pitch;

endmodule

### hw/rtl/toh_ctrl.sv
// Sequencer for pushes and nearest-sample queries.
// Depends on toh_pkg; drives the command struct of toh_datapath.
`timescale 1ns / 1ps

module toh_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_op,
   input  toh_pkg::status_type status,
   output toh_pkg::cmd_type    cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHK   = 3'd1;
   localparam logic [2:0] S_SRCH  = 3'd2;
   localparam logic [2:0] S_NEAR1 = 3'd3;
   localparam logic [2:0] S_NEAR2 = 3'd4;
   localparam logic [2:0] S_LOAD  = 3'd5;
   localparam logic [2:0] S_RESP  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_op == toh_pkg::OP_PUSH) begin
                  cmd.push_wr = 1'b1;
               end else if (status.empty) begin
                  cmd.res_zero = 1'b1;
                  state_in     = S_RESP;
               end else begin
                  cmd.q_start = 1'b1;
                  state_in    = S_CHK;
               end
            end
         end
         S_CHK: begin
            priority if (status.tgt_le_rd) begin
               cmd.res_rd = 1'b1;
               state_in   = S_RESP;
            end else if (status.tgt_ge_newest) begin
               cmd.rd_newest = 1'b1;
               state_in      = S_LOAD;
            end else begin
               cmd.srch_init = 1'b1;
               state_in      = S_SRCH;
            end
         end
         S_SRCH: begin
            cmd.srch_step = 1'b1;
            if (status.srch_done) begin
               state_in = S_NEAR1;
            end
         end
         S_NEAR1: begin
            cmd.near_cur = 1'b1;
            state_in     = S_NEAR2;
         end
         S_NEAR2: begin
            cmd.res_pick = 1'b1;
            state_in     = S_RESP;
         end
         S_LOAD: begin
            cmd.res_rd = 1'b1;
            state_in   = S_RESP;
         end
         S_RESP: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/toh_datapath.sv
// Sample ring, search window and result registers of the history unit.
// Depends on toh_pkg; steered by toh_ctrl through the command struct.
`timescale 1ns / 1ps

module toh_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  toh_pkg::cmd_type               cmd,
   output toh_pkg::status_type            status,
   input  logic [toh_pkg::STAMP_W-1:0]    in_stamp,
   input  logic signed [toh_pkg::VAL_W-1:0] in_w,
   input  logic signed [toh_pkg::VAL_W-1:0] in_x,
   input  logic signed [toh_pkg::VAL_W-1:0] in_y,
   input  logic signed [toh_pkg::VAL_W-1:0] in_z,
   input  logic signed [toh_pkg::VAL_W-1:0] in_yaw,
   input  logic signed [toh_pkg::VAL_W-1:0] in_pitch,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output toh_pkg::result_type            rsp_word
);

   toh_pkg::entry_type mem_ff [toh_pkg::DEPTH];
   toh_pkg::entry_type rd_data_ff;
   toh_pkg::entry_type cand_ff;
   toh_pkg::entry_type wr_entry;

   logic [toh_pkg::IDX_W-1:0]   oldest_ff, oldest_in;
   logic [toh_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [toh_pkg::STAMP_W-1:0] newest_ff;
   logic [toh_pkg::STAMP_W-1:0] tgt_ff;
   logic [toh_pkg::STAMP_W-1:0] dcur_ff;
   logic [toh_pkg::STAMP_W-1:0] dprev;
   logic [toh_pkg::STAMP_W-1:0] wr_stamp;
   logic [toh_pkg::CNT_W-1:0]   lo_ff, lo_in;
   logic [toh_pkg::CNT_W-1:0]   hi_ff, hi_in;
   logic [toh_pkg::CNT_W-1:0]   mid_ff, mid_in;
   logic [toh_pkg::CNT_W:0]     mid_sum;
   logic [toh_pkg::IDX_W-1:0]   wr_addr;
   logic [toh_pkg::IDX_W-1:0]   rd_addr;
   logic                        rd_en;
   logic                        full;
   toh_pkg::result_type         res_ff;
   toh_pkg::result_type         rd_res;
   toh_pkg::result_type         cand_res;
   toh_pkg::result_type         out_ff;
   logic                        out_valid_ff;

   assign full = (count_ff == toh_pkg::CNT_W'(toh_pkg::DEPTH));

   // Push: the stamp never falls below the newest stored one.
   assign wr_stamp = ((count_ff != '0) && (in_stamp < newest_ff)) ? newest_ff : in_stamp;
   assign wr_addr  = full ? oldest_ff : toh_pkg::slot_of(oldest_ff, count_ff);

   always_comb begin
      wr_entry.stamp    = wr_stamp;
      wr_entry.orient_w = in_w;
      wr_entry.orient_x = in_x;
      wr_entry.orient_y = in_y;
      wr_entry.orient_z = in_z;
      wr_entry.yaw      = in_yaw;
      wr_entry.pitch    = in_pitch;
   end

   always_comb begin
      oldest_in = oldest_ff;
      count_in  = count_ff;
      if (cmd.push_wr) begin
         if (full) begin
            oldest_in = (oldest_ff == toh_pkg::IDX_W'(toh_pkg::DEPTH - 1)) ?
                        '0 : oldest_ff + 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   // One search step: halve the window around the stamp just read.
   always_comb begin
      if (rd_data_ff.stamp < tgt_ff) begin
         lo_in = mid_ff + 1'b1;
         hi_in = hi_ff;
      end else begin
         lo_in = lo_ff;
         hi_in = mid_ff;
      end
      mid_sum = (toh_pkg::CNT_W+1)'(lo_in) + (toh_pkg::CNT_W+1)'(hi_in);
      mid_in  = mid_sum[toh_pkg::CNT_W:1];
   end

   always_comb begin
      rd_en   = 1'b1;
      rd_addr = oldest_ff;
      priority if (cmd.q_start) begin
         rd_addr = oldest_ff;
      end else if (cmd.rd_newest) begin
         rd_addr = toh_pkg::slot_of(oldest_ff, count_ff - 1'b1);
      end else if (cmd.srch_init) begin
         rd_addr = toh_pkg::slot_of(oldest_ff, count_ff >> 1);
      end else if (cmd.srch_step) begin
         rd_addr = (lo_in < hi_in) ? toh_pkg::slot_of(oldest_ff, mid_in) :
                                     toh_pkg::slot_of(oldest_ff, lo_in);
      end else if (cmd.near_cur) begin
         rd_addr = toh_pkg::slot_of(oldest_ff, lo_ff - 1'b1);
      end else begin
         rd_en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push_wr) begin
         mem_ff[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_comb begin
      rd_res.found    = 1'b1;
      rd_res.orient_w = rd_data_ff.orient_w;
      rd_res.orient_x = rd_data_ff.orient_x;
      rd_res.orient_y = rd_data_ff.orient_y;
      rd_res.orient_z = rd_data_ff.orient_z;
      rd_res.yaw      = rd_data_ff.yaw;
      rd_res.pitch    = rd_data_ff.pitch;
      cand_res.found    = 1'b1;
      cand_res.orient_w = cand_ff.orient_w;
      cand_res.orient_x = cand_ff.orient_x;
      cand_res.orient_y = cand_ff.orient_y;
      cand_res.orient_z = cand_ff.orient_z;
      cand_res.yaw      = cand_ff.yaw;
      cand_res.pitch    = cand_ff.pitch;
   end

   // Distance from the target back to the predecessor just read.
   assign dprev = tgt_ff - rd_data_ff.stamp;

   always_ff @(posedge clock) begin
      if (cmd.push_wr) begin
         newest_ff <= wr_stamp;
      end
      if (cmd.q_start) begin
         tgt_ff <= in_stamp;
      end
      if (cmd.srch_init) begin
         lo_ff  <= '0;
         hi_ff  <= count_ff;
         mid_ff <= count_ff >> 1;
      end else if (cmd.srch_step) begin
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
         mid_ff <= mid_in;
      end
      if (cmd.near_cur) begin
         cand_ff <= rd_data_ff;
         dcur_ff <= rd_data_ff.stamp - tgt_ff;
      end
      if (cmd.res_zero) begin
         res_ff <= '0;
      end else if (cmd.res_rd) begin
         res_ff <= rd_res;
      end else if (cmd.res_pick) begin
         res_ff <= (dprev < dcur_ff) ? rd_res : cand_res;
      end
      if (cmd.out_load) begin
         out_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff    <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         oldest_ff <= oldest_in;
         count_ff  <= count_in;
         if (cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign status.empty         = (count_ff == '0);
   assign status.tgt_le_rd     = (tgt_ff <= rd_data_ff.stamp);
   assign status.tgt_ge_newest = (tgt_ff >= newest_ff);
   assign status.srch_done     = !(lo_in < hi_in);
   assign status.out_free      = !out_valid_ff || rsp_ready;

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;

endmodule

### tb/tb_top.sv
// Self-checking testbench for timestamped_orientation_history_unit.
// Drives push and query words, predicts each nearest-sample answer and checks it.
// Depends on toh_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module tb_top;

   localparam logic [toh_pkg::STAMP_W-1:0] STAMP_MAX = '1;

   // Even with both sides stalling heavily the whole run stays far below this bound.
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_WORDS = 1180;
   localparam int DRAIN_CYCLES = 30;
   localparam int REPORT_MAX   = 10;

   // One request word as the driver presents it.
   typedef struct packed {
      logic                             op;
      logic [toh_pkg::STAMP_W-1:0]      stamp;
      logic signed [toh_pkg::VAL_W-1:0] w;
      logic signed [toh_pkg::VAL_W-1:0] x;
      logic signed [toh_pkg::VAL_W-1:0] y;
      logic signed [toh_pkg::VAL_W-1:0] z;
      logic signed [toh_pkg::VAL_W-1:0] yaw;
      logic signed [toh_pkg::VAL_W-1:0] pitch;
   } sample_word_type;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_valid;
   logic                             req_ready;
   logic                             req_op;
   logic [toh_pkg::STAMP_W-1:0]      req_stamp_us;
   logic signed [toh_pkg::VAL_W-1:0] req_orient_w;
   logic signed [toh_pkg::VAL_W-1:0] req_orient_x;
   logic signed [toh_pkg::VAL_W-1:0] req_orient_y;
   logic signed [toh_pkg::VAL_W-1:0] req_orient_z;
   logic signed [toh_pkg::VAL_W-1:0] req_yaw_angle;
   logic signed [toh_pkg::VAL_W-1:0] req_pitch_angle;
   logic                             rsp_valid;
   logic                             rsp_ready;
   logic                             rsp_found;
   logic signed [toh_pkg::VAL_W-1:0] rsp_res_orient_w;
   logic signed [toh_pkg::VAL_W-1:0] rsp_res_orient_x;
   logic signed [toh_pkg::VAL_W-1:0] rsp_res_orient_y;
   logic signed [toh_pkg::VAL_W-1:0] rsp_res_orient_z;
   logic signed [toh_pkg::VAL_W-1:0] rsp_res_yaw;
   logic signed [toh_pkg::VAL_W-1:0] rsp_res_pitch;

   // Words waiting to be driven, and answers waiting to come back.
   sample_word_type     pending_words [$];
   toh_pkg::result_type expected_answers [$];

   // Stamps as the stimulus generator believes the ring holds them, used only
   // to aim query targets at interesting spots.
   logic [toh_pkg::STAMP_W-1:0] gen_stamps [$];

   // The checker's own copy of the history ring.
   toh_pkg::entry_type hist_entry [toh_pkg::DEPTH];
   int                 hist_oldest;
   int                 hist_count;

   bit req_taken;
   int total_words;
   int words_sent;
   int cycle_count;
   int fail_count;
   int report_count;

   // Coverage tallies for the closing summary.
   int n_push, n_query, n_empty, n_low, n_high, n_inside, n_prev, n_tie, n_wrap, n_sat;

   timestamped_orientation_history_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_stamp_us     (req_stamp_us),
      .req_orient_w     (req_orient_w),
      .req_orient_x     (req_orient_x),
      .req_orient_y     (req_orient_y),
      .req_orient_z     (req_orient_z),
      .req_yaw_angle    (req_yaw_angle),
      .req_pitch_angle  (req_pitch_angle),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_res_orient_w (rsp_res_orient_w),
      .rsp_res_orient_x (rsp_res_orient_x),
      .rsp_res_orient_y (rsp_res_orient_y),
      .rsp_res_orient_z (rsp_res_orient_z),
      .rsp_res_yaw      (rsp_res_yaw),
      .rsp_res_pitch    (rsp_res_pitch)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------
   // History predictor
   // ------------------------------------------------------------------

   // Physical slot of logical position pos, where position 0 is the oldest.
   function automatic int hist_slot(input int pos);
      return (hist_oldest + pos) % toh_pkg::DEPTH;
   endfunction

   // Store one pushed sample. A stamp that would go backward is held at the
   // newest stored stamp so the ring stays sorted; a full ring loses its oldest.
   task automatic store_sample(input sample_word_type s);
      logic [toh_pkg::STAMP_W-1:0] kept;
      int                          slot;
      begin
         kept = s.stamp;
         if (hist_count > 0 && kept < hist_entry[hist_slot(hist_count - 1)].stamp) begin
            kept = hist_entry[hist_slot(hist_count - 1)].stamp;
            n_sat++;
         end
         if (hist_count < toh_pkg::DEPTH) begin
            slot = hist_slot(hist_count);
            hist_count++;
         end else begin
            slot = hist_oldest;
            hist_oldest = (hist_oldest + 1) % toh_pkg::DEPTH;
            n_wrap++;
         end
         hist_entry[slot].stamp    = kept;
         hist_entry[slot].orient_w = s.w;
         hist_entry[slot].orient_x = s.x;
         hist_entry[slot].orient_y = s.y;
         hist_entry[slot].orient_z = s.z;
         hist_entry[slot].yaw      = s.yaw;
         hist_entry[slot].pitch    = s.pitch;
         n_push++;
      end
   endtask

   // Work out the answer to a query: the sample nearest to target, the later
   // one when two are equally near, clamped at both ends of the stored span.
   task automatic lookup_nearest(input logic [toh_pkg::STAMP_W-1:0] target,
                                 output toh_pkg::result_type ans);
      int                          pick;
      int                          pos;
      logic [toh_pkg::STAMP_W-1:0] cur_s;
      logic [toh_pkg::STAMP_W-1:0] prev_s;
      toh_pkg::entry_type          e;
      begin
         ans  = '0;
         pick = 0;
         n_query++;
         if (hist_count == 0) begin
            n_empty++;
         end else begin
            if (target <= hist_entry[hist_slot(0)].stamp) begin
               pick = 0;
               n_low++;
            end else if (target >= hist_entry[hist_slot(hist_count - 1)].stamp) begin
               pick = hist_count - 1;
               n_high++;
            end else begin
               // The ring is sorted, so a plain scan finds the first stamp at or
               // after the target; it must lie strictly inside the span.
               pos = 1;
               while (hist_entry[hist_slot(pos)].stamp < target) begin
                  pos++;
               end
               cur_s  = hist_entry[hist_slot(pos)].stamp;
               prev_s = hist_entry[hist_slot(pos - 1)].stamp;
               pick   = pos;
               if ((target - prev_s) < (cur_s - target)) begin
                  pick = pos - 1;
                  n_prev++;
               end else if ((target - prev_s) == (cur_s - target)) begin
                  n_tie++;
               end
               n_inside++;
            end
            e = hist_entry[hist_slot(pick)];
            ans.found    = 1'b1;
            ans.orient_w = e.orient_w;
            ans.orient_x = e.orient_x;
            ans.orient_y = e.orient_y;
            ans.orient_z = e.orient_z;
            ans.yaw      = e.yaw;
            ans.pitch    = e.pitch;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus generation
   // ------------------------------------------------------------------

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // A 16-bit field value, with the extremes and the values around zero
   // showing up more often than pure chance would give.
   function automatic logic signed [toh_pkg::VAL_W-1:0] rand_val16();
      logic signed [toh_pkg::VAL_W-1:0] v;
      begin
         v = 16'($urandom);
         if ($urandom_range(99) < 12) begin
            case ($urandom_range(3))
               0: v = 16'sh7FFF;
               1: v = 16'sh8000;
               2: v = 16'sh0000;
               default: v = 16'shFFFF;
            endcase
         end
         return v;
      end
   endfunction

   task automatic add_push(input logic [toh_pkg::STAMP_W-1:0] stamp,
                           input logic signed [toh_pkg::VAL_W-1:0] w, x, y, z, yaw, pitch);
      sample_word_type             s;
      logic [toh_pkg::STAMP_W-1:0] kept;
      begin
         kept = stamp;
         if (gen_stamps.size() != 0 && kept < gen_stamps[$]) begin
            kept = gen_stamps[$];
         end
         gen_stamps.insert(gen_stamps.size(), kept);
         if (gen_stamps.size() > toh_pkg::DEPTH) begin
            gen_stamps.delete(0);
         end
         s.op    = toh_pkg::OP_PUSH;
         s.stamp = stamp;
         s.w     = w;
         s.x     = x;
         s.y     = y;
         s.z     = z;
         s.yaw   = yaw;
         s.pitch = pitch;
         pending_words.insert(pending_words.size(), s);
      end
   endtask

   // Query words carry random junk in the sample fields, which the unit
   // must ignore.
   task automatic add_query(input logic [toh_pkg::STAMP_W-1:0] target);
      sample_word_type s;
      begin
         s.op    = toh_pkg::OP_QUERY;
         s.stamp = target;
         s.w     = 16'($urandom);
         s.x     = 16'($urandom);
         s.y     = 16'($urandom);
         s.z     = 16'($urandom);
         s.yaw   = 16'($urandom);
         s.pitch = 16'($urandom);
         pending_words.insert(pending_words.size(), s);
      end
   endtask

   // Push stamps mostly climb slowly, with repeats, medium and rare large
   // jumps, and now and then a step backward that the unit must hold level.
   function automatic logic [toh_pkg::STAMP_W-1:0] next_push_stamp();
      logic [63:0] last;
      logic [63:0] nxt;
      int unsigned r;
      begin
         last = (gen_stamps.size() != 0) ? 64'(gen_stamps[$]) : 64'd0;
         r    = $urandom_range(99);
         if (r < 20) begin
            nxt = last;
         end else if (r < 65) begin
            nxt = last + $urandom_range(1000, 1);
         end else if (r < 80) begin
            nxt = last + ($urandom & 32'h000F_FFFF);
         end else if (r < 85) begin
            nxt = last + (rand64() & 64'h0000_00FF_FFFF_FFFF);
         end else if (last == 0) begin
            nxt = rand64() & 64'hFFFF;
         end else begin
            nxt = rand64() % last;
         end
         if (nxt > 64'(STAMP_MAX)) begin
            nxt = last;
         end
         return nxt[toh_pkg::STAMP_W-1:0];
      end
   endfunction

   // Query targets aim at the edges of the span, exact stamps, midpoints of
   // neighbors (ties) and one off either side of them, or fall at random.
   function automatic logic [toh_pkg::STAMP_W-1:0] pick_target();
      logic [63:0] lo_s;
      logic [63:0] hi_s;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] mid;
      logic [63:0] t;
      int          n;
      int          k;
      int unsigned r;
      begin
         n = gen_stamps.size();
         r = $urandom_range(99);
         t = rand64() & 64'(STAMP_MAX);
         if (n != 0 && r >= 8) begin
            lo_s = 64'(gen_stamps[0]);
            hi_s = 64'(gen_stamps[n - 1]);
            if (r < 18) begin
               t = $urandom_range(1) ? lo_s : lo_s - (rand64() % (lo_s + 1));
            end else if (r < 28) begin
               t = $urandom_range(1) ? hi_s : hi_s + (rand64() % (64'(STAMP_MAX) - hi_s + 1));
            end else if (r < 48 || n < 2) begin
               t = 64'(gen_stamps[$urandom_range(n - 1)]);
            end else begin
               k   = $urandom_range(n - 2);
               a   = 64'(gen_stamps[k]);
               b   = 64'(gen_stamps[k + 1]);
               mid = a + (b - a) / 2;
               if (r < 68) begin
                  t = mid;
               end else if (r < 88) begin
                  t = ($urandom_range(1) || mid == 0) ? mid + 1 : mid - 1;
               end else begin
                  t = lo_s + (rand64() % (hi_s - lo_s + 1));
               end
            end
         end
         return t[toh_pkg::STAMP_W-1:0];
      end
   endfunction

   // ------------------------------------------------------------------
   // Driver: presents words at the falling edge, holds each one until the
   // rising edge that accepts it, and sets both sides' idling per phase.
   // ------------------------------------------------------------------
   always @(negedge clock) begin : driver
      int              idle_pct;
      int              stall_pct;
      sample_word_type s;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         // First third: the sender idles less, the receiver more; second
         // third swapped; last third runs flat out on both sides.
         if (words_sent < total_words / 3) begin
            idle_pct  = 32;
            stall_pct = 55;
         end else if (words_sent < (2 * total_words) / 3) begin
            idle_pct  = 55;
            stall_pct = 32;
         end else begin
            idle_pct  = 0;
            stall_pct = 0;
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);

         // Only a free channel takes a new word; a word already on the port
         // stays put until it has been accepted.
         if (!req_valid || req_taken) begin
            req_taken = 1'b0;
            if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
               s = pending_words[0];
               pending_words.delete(0);
               words_sent++;
               req_valid       <= 1'b1;
               req_op          <= s.op;
               req_stamp_us    <= s.stamp;
               req_orient_w    <= s.w;
               req_orient_x    <= s.x;
               req_orient_y    <= s.y;
               req_orient_z    <= s.z;
               req_yaw_angle   <= s.yaw;
               req_pitch_angle <= s.pitch;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: at each rising edge, an accepted request word updates the
   // predictor, and an accepted result word is checked against the oldest
   // answer still expected.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      sample_word_type     s;
      toh_pkg::result_type ans;
      toh_pkg::result_type got;
      toh_pkg::result_type want;
      if (!reset) begin
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d answers outstanding",
                     cycle_count, expected_answers.size());
            $display("CHECKS FAILED");
            $finish;
         end else begin
            if (req_valid && req_ready) begin
               req_taken = 1'b1;
               s.op    = req_op;
               s.stamp = req_stamp_us;
               s.w     = req_orient_w;
               s.x     = req_orient_x;
               s.y     = req_orient_y;
               s.z     = req_orient_z;
               s.yaw   = req_yaw_angle;
               s.pitch = req_pitch_angle;
               if (s.op == toh_pkg::OP_PUSH) begin
                  store_sample(s);
               end else begin
                  lookup_nearest(s.stamp, ans);
                  expected_answers.insert(expected_answers.size(), ans);
               end
            end

            if (rsp_valid && rsp_ready) begin
               got.found    = rsp_found;
               got.orient_w = rsp_res_orient_w;
               got.orient_x = rsp_res_orient_x;
               got.orient_y = rsp_res_orient_y;
               got.orient_z = rsp_res_orient_z;
               got.yaw      = rsp_res_yaw;
               got.pitch    = rsp_res_pitch;
               if (expected_answers.size() == 0) begin
                  fail_count++;
                  if (report_count < REPORT_MAX) begin
                     $display("Cycle %0d: result word with no query waiting for it",
                              cycle_count);
                  end
                  report_count++;
               end else begin
                  want = expected_answers[0];
                  expected_answers.delete(0);
                  if (got.found !== want.found || got.orient_w !== want.orient_w ||
                      got.orient_x !== want.orient_x || got.orient_y !== want.orient_y ||
                      got.orient_z !== want.orient_z || got.yaw !== want.yaw ||
                      got.pitch !== want.pitch) begin
                     fail_count++;
                     if (report_count < REPORT_MAX) begin
                        $display("Cycle %0d: answer mismatch", cycle_count);
                        $display("  exp found=%0d w=%0d x=%0d y=%0d z=%0d yaw=%0d pitch=%0d",
                                 want.found, want.orient_w, want.orient_x, want.orient_y,
                                 want.orient_z, want.yaw, want.pitch);
                        $display("  got found=%0d w=%0d x=%0d y=%0d z=%0d yaw=%0d pitch=%0d",
                                 got.found, got.orient_w, got.orient_x, got.orient_y,
                                 got.orient_z, got.yaw, got.pitch);
                     end
                     report_count++;
                  end
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Sequence: reset, build the stimulus, wait for it to drain, verdict.
   // ------------------------------------------------------------------
   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_op          = toh_pkg::OP_PUSH;
      req_stamp_us    = '0;
      req_orient_w    = '0;
      req_orient_x    = '0;
      req_orient_y    = '0;
      req_orient_z    = '0;
      req_yaw_angle   = '0;
      req_pitch_angle = '0;
      rsp_ready       = 1'b0;
      req_taken       = 1'b0;
      hist_oldest     = 0;
      hist_count      = 0;

      // Directed opening. Queries on an empty history come first, then a
      // handful of samples with hand-picked stamps: a backward stamp that is
      // held level (leaving two equal stamps), an exact tie between
      // neighbors, one off either side of it, and both clamps.
      add_query('0);
      add_query(STAMP_MAX);
      add_push(48'd0, 16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001, 16'sh4000);
      add_query('0);
      add_query(STAMP_MAX);
      add_push(48'd100, 16'sh8000, 16'sh7FFF, 16'shFFFF, 16'sh0000, 16'shC000, 16'sh7FFF);
      add_push(48'd50, 16'sh1234, 16'shEDCB, 16'sh5555, 16'shAAAA, 16'sh8000, 16'sh0000);
      add_query(48'd100);
      add_push(48'd200, 16'sh0F0F, 16'shF0F0, 16'sh3333, 16'shCCCC, 16'sh7FFF, 16'sh8001);
      add_query(48'd150);
      add_query(48'd149);
      add_query(48'd151);
      add_query(48'd99);
      add_query(48'd1);
      add_push(48'd301, 16'sh2468, 16'shDB97, 16'sh0101, 16'shFEFE, 16'sh1111, 16'shEEEE);
      add_query(48'd250);
      add_query(48'd251);
      add_query(48'd301);

      // Random part: a mix of pushes and aimed queries that fills the ring,
      // wraps it many times and keeps the stamps well ordered.
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if ($urandom_range(99) < 55) begin
            add_push(next_push_stamp(), rand_val16(), rand_val16(), rand_val16(),
                     rand_val16(), rand_val16(), rand_val16());
         end else begin
            add_query(pick_target());
         end
      end

      // Closing words: the largest stamp, queries at both ends, and a push
      // going backward from the top, which must be held at the top.
      add_push(STAMP_MAX, rand_val16(), rand_val16(), rand_val16(),
               rand_val16(), rand_val16(), rand_val16());
      add_query(STAMP_MAX);
      add_query('0);
      add_query(STAMP_MAX - 1);
      add_push(48'd5, rand_val16(), rand_val16(), rand_val16(),
               rand_val16(), rand_val16(), rand_val16());
      add_query(STAMP_MAX - 1);
      add_query(STAMP_MAX);
      total_words = pending_words.size();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      while (expected_answers.size() != 0) begin
         @(posedge clock);
      end
      // Give a stray extra result word time to show up.
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d pushes (%0d held-level stamps, %0d overwrites of the oldest)",
               n_push, n_sat, n_wrap);
      $display("and %0d queries: %0d empty, %0d low clamp, %0d high clamp, %0d inside (%0d %s",
               n_query, n_empty, n_low, n_high, n_inside, n_prev,
               $sformatf("earlier neighbor, %0d ties), %0d mismatches", n_tie, fail_count));
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
